[sv/cae_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cae_pkg
// Shared types, constants and checksum functions for the checksummed address
// encoder: polymod fold, zero-flush matrix, alphabet lookup, status codes.
// ----------------------------------------------------------------------------
package cae_pkg;

    // checksum geometry
    localparam int unsigned CHK_W         = 40;
    localparam int unsigned SYM_W         = 5;
    localparam int unsigned CHECK_SYMBOLS = 8;
    localparam int unsigned CHK_CNT_W     = $clog2(CHECK_SYMBOLS + 1);
    localparam int unsigned MAX_LENGTH    = 90;
    localparam int unsigned COUNT_W       = 7;
    // total count above this value makes the address too long
    localparam int unsigned LEN_LIMIT     = MAX_LENGTH - CHECK_SYMBOLS - 1;

    // generator terms, one per bit of the top group
    localparam logic [CHK_W-1:0] GEN0 = 40'h98f2bc8e61;
    localparam logic [CHK_W-1:0] GEN1 = 40'h79b76d99e2;
    localparam logic [CHK_W-1:0] GEN2 = 40'hf33e5fb3c4;
    localparam logic [CHK_W-1:0] GEN3 = 40'hae2eabe2a8;
    localparam logic [CHK_W-1:0] GEN4 = 40'h1e4f43e470;
    localparam logic [CHK_W-1:0] CHK_INIT = 40'h1;

    // character constants
    localparam logic [7:0] SEP_CHAR   = 8'h3A;
    localparam logic [7:0] CHAR_MIN   = 8'd33;
    localparam logic [7:0] CHAR_MAX   = 8'd126;
    localparam logic [7:0] UPPER_MIN  = 8'h41;
    localparam logic [7:0] UPPER_MAX  = 8'h5A;
    localparam logic [7:0] SYM_MAX    = 8'd31;

    // 32-letter alphabet, index 0 is the rightmost character of the string
    localparam logic [31:0][7:0] ALPHABET = "l7aum6echk45nj3s0wdvt2fg8x9yrzpq";

    // status codes reported on the final word
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_CHAR  = 3'd1,
        ST_UPPER     = 3'd2,
        ST_TOO_LONG  = 3'd3,
        ST_SYM_RANGE = 3'd4,
        ST_ORDER     = 3'd5
    } status_t;

    // one item's results as handed to the output buffer
    typedef struct packed {
        logic [7:0]       lead0;
        logic [7:0]       lead1;
        logic [1:0]       lead_cnt;
        logic             flush;
        logic [CHK_W-1:0] chk_pre;
        status_t          status;
    } cae_load_t;

    typedef logic [CHK_W-1:0][CHK_W-1:0] flush_mat_t;

    // one polymod step: shift in a 5-bit symbol and reduce
    function automatic logic [CHK_W-1:0] cae_fold(input logic [CHK_W-1:0] acc,
                                                  input logic [SYM_W-1:0] sym);
        logic [SYM_W-1:0] top;
        logic [CHK_W-1:0] r;
        top = acc[CHK_W-1 -: SYM_W];
        r   = {acc[CHK_W-SYM_W-1:0], sym};
        if (top[0]) r = r ^ GEN0;
        if (top[1]) r = r ^ GEN1;
        if (top[2]) r = r ^ GEN2;
        if (top[3]) r = r ^ GEN3;
        if (top[4]) r = r ^ GEN4;
        return r;
    endfunction

    // columns of the linear map that folds in the trailing zero symbols
    function automatic flush_mat_t cae_flush_cols();
        flush_mat_t       m;
        logic [CHK_W-1:0] c;
        for (int i = 0; i < CHK_W; i++) begin
            c = CHK_W'(1) << i;
            for (int k = 0; k < CHECK_SYMBOLS; k++) begin
                c = cae_fold(c, SYM_W'(0));
            end
            m[i] = c;
        end
        return m;
    endfunction

    localparam flush_mat_t FLUSH_COLS = cae_flush_cols();

    // fold in all trailing zeros at once: xor of the selected columns
    function automatic logic [CHK_W-1:0] cae_flush(input logic [CHK_W-1:0] c);
        logic [CHK_W-1:0] r;
        r = '0;
        for (int i = 0; i < CHK_W; i++) begin
            if (c[i]) r = r ^ FLUSH_COLS[i];
        end
        return r;
    endfunction

    function automatic logic [7:0] cae_alpha(input logic [SYM_W-1:0] idx);
        return ALPHABET[idx];
    endfunction

endpackage

[sv/checksummed_address_encoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checksummed_address_encoder
// Streams a checksummed address from prefix bytes and 5-bit data symbols,
// keeping a 40-bit polymod checksum and appending eight checksum characters.
//
//   channel | direction | payload                          | handshake
//   s_      | in        | s_cmd, s_value, s_last           | s_valid / s_ready
//   m_      | out       | m_out_char, m_final_res, m_status | m_valid / m_ready
//
// A word taken into the input register moves on to the output buffer once
// the buffer can load it; its first character is then offered from there.
// Prefix bytes and later data symbols give one word each, one item per cycle
// while m_ready is high. The first data symbol gives two words; the last item
// gives 9 or 10 words, drained one character per cycle while m_ready is high.
// Reset is synchronous on aresetn and returns the checksum to its start value.
// With m_ready low the buffer holds, and one more item waits in the input
// register before s_ready drops.
// ----------------------------------------------------------------------------
module checksummed_address_encoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_cmd,
    input  logic [7:0] s_value,
    input  logic       s_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_char,
    output logic       m_final_res,
    output logic [2:0] m_status
);
    import cae_pkg::*;

    // input register
    logic       in_valid_reg, in_valid_next;
    logic       in_cmd_reg;
    logic [7:0] in_value_reg;
    logic       in_last_reg;

    // address state
    logic [CHK_W-1:0]   chk_reg, chk_next;
    logic               in_data_reg, in_data_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    status_t            err_reg, err_next;

    logic      load;
    logic      can_load;
    logic      s_take;
    cae_load_t load_word;

    // work signals of the item in the input register
    logic [CHK_W-1:0]   chk_item;
    status_t            err_item;
    logic [SYM_W-1:0]   sym;
    logic [7:0]         lead0;
    logic [7:0]         lead1;
    logic [1:0]         lead_cnt;
    logic [COUNT_W:0]   count_sum;
    logic [COUNT_W-1:0] count_item;

    assign load    = in_valid_reg && can_load;
    assign s_ready = !in_valid_reg || load;
    assign s_take  = s_valid && s_ready;
    assign sym     = in_value_reg[SYM_W-1:0];

    // input register
    always_comb begin
        in_valid_next = s_take || (in_valid_reg && !load);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_cmd_reg   <= s_cmd;
            in_value_reg <= s_value;
            in_last_reg  <= s_last;
        end
    end

    // fold the item and build its lead characters
    always_comb begin
        chk_item = chk_reg;
        err_item = err_reg;
        lead0    = in_value_reg;
        lead1    = in_value_reg;
        lead_cnt = 2'd1;
        if (!in_cmd_reg) begin
            // prefix byte: echoed and folded, checked for range and case
            if (in_data_reg && err_item == ST_OK) begin
                err_item = ST_ORDER;
            end
            if (err_item == ST_OK) begin
                if (in_value_reg < CHAR_MIN || in_value_reg > CHAR_MAX) begin
                    err_item = ST_BAD_CHAR;
                end else if (in_value_reg >= UPPER_MIN && in_value_reg <= UPPER_MAX) begin
                    err_item = ST_UPPER;
                end
            end
            chk_item = cae_fold(chk_item, sym);
            // empty data part: separator follows the last prefix byte
            if (in_last_reg && !in_data_reg) begin
                chk_item = cae_fold(chk_item, SYM_W'(0));
                lead1    = SEP_CHAR;
                lead_cnt = 2'd2;
            end
        end else begin
            // data symbol: the first one brings the separator
            if (!in_data_reg) begin
                chk_item = cae_fold(chk_item, SYM_W'(0));
                lead0    = SEP_CHAR;
                lead1    = cae_alpha(sym);
                lead_cnt = 2'd2;
            end else begin
                lead0    = cae_alpha(sym);
            end
            if (in_value_reg > SYM_MAX && err_item == ST_OK) begin
                err_item = ST_SYM_RANGE;
            end
            chk_item = cae_fold(chk_item, sym);
        end

        // saturating character count
        count_sum  = {1'b0, count_reg} + (COUNT_W+1)'(lead_cnt);
        count_item = count_sum[COUNT_W] ? '1 : count_sum[COUNT_W-1:0];

        if (in_last_reg && err_item == ST_OK && count_item > COUNT_W'(LEN_LIMIT)) begin
            err_item = ST_TOO_LONG;
        end
    end

    // state update and buffer load word
    always_comb begin
        chk_next     = chk_reg;
        in_data_next = in_data_reg;
        count_next   = count_reg;
        err_next     = err_reg;
        if (load) begin
            if (in_last_reg) begin
                chk_next     = CHK_INIT;
                in_data_next = 1'b0;
                count_next   = '0;
                err_next     = ST_OK;
            end else begin
                chk_next     = chk_item;
                in_data_next = in_data_reg || in_cmd_reg;
                count_next   = count_item;
                err_next     = err_item;
            end
        end
        load_word.lead0    = lead0;
        load_word.lead1    = lead1;
        load_word.lead_cnt = lead_cnt;
        load_word.flush    = in_last_reg;
        load_word.chk_pre  = chk_item;
        load_word.status   = in_last_reg ? err_item : ST_OK;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chk_reg     <= CHK_INIT;
            in_data_reg <= 1'b0;
            count_reg   <= '0;
            err_reg     <= ST_OK;
        end else begin
            chk_reg     <= chk_next;
            in_data_reg <= in_data_next;
            count_reg   <= count_next;
            err_reg     <= err_next;
        end
    end

    // output buffer
    cae_emitter u_emitter (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (load),
        .load_word   (load_word),
        .can_load    (can_load),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_char  (m_out_char),
        .m_final_res (m_final_res),
        .m_status    (m_status)
    );

endmodule

[sv/cae_emitter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cae_emitter
// Output buffer: holds the lead characters of one item and, for the final
// item, expands the checksum into characters, one word per cycle with m_ready.
// ----------------------------------------------------------------------------
module cae_emitter (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  cae_pkg::cae_load_t load_word,
    output logic               can_load,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_out_char,
    output logic               m_final_res,
    output logic [2:0]         m_status
);
    import cae_pkg::*;

    logic [7:0]           lead0_reg, lead0_next;
    logic [7:0]           lead1_reg, lead1_next;
    logic [1:0]           lead_cnt_reg, lead_cnt_next;
    logic [CHK_CNT_W-1:0] chk_cnt_reg, chk_cnt_next;
    logic                 calc_reg, calc_next;
    logic [CHK_W-1:0]     chk_pre_reg, chk_pre_next;
    logic [CHK_W-1:0]     chk_out_reg, chk_out_next;
    status_t              status_reg, status_next;

    logic take;
    logic one_left;
    logic in_lead;

    // output side
    assign in_lead     = (lead_cnt_reg != 2'd0);
    assign m_valid     = in_lead || (chk_cnt_reg != '0);
    assign take        = m_valid && m_ready;
    assign one_left    = (lead_cnt_reg == 2'd1 && chk_cnt_reg == '0) ||
                         (lead_cnt_reg == 2'd0 && chk_cnt_reg == CHK_CNT_W'(1));
    assign can_load    = !m_valid || (m_ready && one_left);
    assign m_out_char  = in_lead ? lead0_reg : cae_alpha(chk_out_reg[CHK_W-1 -: SYM_W]);
    assign m_final_res = !in_lead && (chk_cnt_reg == CHK_CNT_W'(1));
    assign m_status    = m_final_res ? status_reg : ST_OK;

    // buffer next state
    always_comb begin
        lead0_next    = lead0_reg;
        lead1_next    = lead1_reg;
        lead_cnt_next = lead_cnt_reg;
        chk_cnt_next  = chk_cnt_reg;
        calc_next     = 1'b0;
        chk_pre_next  = chk_pre_reg;
        chk_out_next  = chk_out_reg;
        status_next   = status_reg;
        // final checksum forms in the cycle after the load, before the lead drains
        if (calc_reg) begin
            chk_out_next = cae_flush(chk_pre_reg) ^ CHK_INIT;
        end
        if (load) begin
            lead0_next    = load_word.lead0;
            lead1_next    = load_word.lead1;
            lead_cnt_next = load_word.lead_cnt;
            chk_cnt_next  = load_word.flush ? CHK_CNT_W'(CHECK_SYMBOLS) : '0;
            calc_next     = load_word.flush;
            chk_pre_next  = load_word.chk_pre;
            status_next   = load_word.status;
        end else if (take) begin
            if (in_lead) begin
                lead0_next    = lead1_reg;
                lead_cnt_next = lead_cnt_reg - 2'd1;
            end else begin
                chk_cnt_next  = chk_cnt_reg - CHK_CNT_W'(1);
                chk_out_next  = chk_out_reg << SYM_W;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lead_cnt_reg <= 2'd0;
            chk_cnt_reg  <= '0;
            calc_reg     <= 1'b0;
        end else begin
            lead_cnt_reg <= lead_cnt_next;
            chk_cnt_reg  <= chk_cnt_next;
            calc_reg     <= calc_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        lead0_reg   <= lead0_next;
        lead1_reg   <= lead1_next;
        chk_pre_reg <= chk_pre_next;
        chk_out_reg <= chk_out_next;
        status_reg  <= status_next;
    end

endmodule

[verif/addr_char_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// addr_char_checker
// Watches both channels of the checksummed address encoder. Every accepted
// input word is run through a local copy of the encoder (polymod checksum,
// separator, alphabet mapping, sticky status) and the characters it should
// produce are queued; every accepted output word is compared field by field
// with the oldest queued character.
// ----------------------------------------------------------------------------
module addr_char_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic       s_cmd,
    input  logic [7:0] s_value,
    input  logic       s_last,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_out_char,
    input  logic       m_final_res,
    input  logic [2:0] m_status,
    output int         err_count,
    output int         pending
);
    import cae_pkg::*;

    localparam logic [39:0] POLY_G0 = 40'h98f2bc8e61;
    localparam logic [39:0] POLY_G1 = 40'h79b76d99e2;
    localparam logic [39:0] POLY_G2 = 40'hf33e5fb3c4;
    localparam logic [39:0] POLY_G3 = 40'hae2eabe2a8;
    localparam logic [39:0] POLY_G4 = 40'h1e4f43e470;
    localparam int          ADDR_MAX_LEN = 90;
    localparam int          CHK_CHARS    = 8;
    // element 0 is the leftmost letter
    localparam logic [0:31][7:0] CHARSET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
        status_t    st;
    } addr_char_t;

    // encoder state as the block should hold it
    logic [39:0] chk;
    logic        in_data;
    logic [6:0]  n_chars;
    status_t     first_err;

    addr_char_t  exp_chars[$];
    addr_char_t  word_buf[10];
    int          n_buf;

    // shift one 5-bit symbol into the checksum and reduce
    function automatic logic [39:0] poly_step(input logic [39:0] acc,
                                              input logic [4:0] sym);
        logic [4:0]  hi;
        logic [39:0] r;
        hi = acc[39:35];
        r  = {acc[34:0], sym};
        if (hi[0]) r = r ^ POLY_G0;
        if (hi[1]) r = r ^ POLY_G1;
        if (hi[2]) r = r ^ POLY_G2;
        if (hi[3]) r = r ^ POLY_G3;
        if (hi[4]) r = r ^ POLY_G4;
        return r;
    endfunction

    task automatic clear_state();
        chk       = 40'h1;
        in_data   = 1'b0;
        n_chars   = '0;
        first_err = ST_OK;
    endtask

    // only the first fault of an address is kept
    task automatic note_fault(input status_t code);
        if (first_err == ST_OK) first_err = code;
    endtask

    task automatic put_char(input logic [7:0] c);
        word_buf[n_buf] = '{ch: c, fin: 1'b0, st: ST_OK};
        n_buf = n_buf + 1;
        if (n_chars != 7'h7f) n_chars = n_chars + 7'd1;
    endtask

    // characters that one input word should produce
    task automatic predict_chars(input logic cmd, input logic [7:0] val,
                                 input logic last);
        status_t st;
        int      i;
        n_buf = 0;
        if (!cmd) begin
            // prefix byte: echoed and folded whatever its value
            if (in_data) note_fault(ST_ORDER);
            if (val < CHAR_MIN || val > CHAR_MAX) note_fault(ST_BAD_CHAR);
            else if (val >= UPPER_MIN && val <= UPPER_MAX) note_fault(ST_UPPER);
            chk = poly_step(chk, val[4:0]);
            put_char(val);
        end else begin
            // first data symbol brings the separator
            if (!in_data) begin
                chk = poly_step(chk, 5'd0);
                put_char(SEP_CHAR);
                in_data = 1'b1;
            end
            if (val > SYM_MAX) note_fault(ST_SYM_RANGE);
            chk = poly_step(chk, val[4:0]);
            put_char(CHARSET[val[4:0]]);
        end

        if (last) begin
            // address with no data part still gets its separator
            if (!in_data) begin
                chk = poly_step(chk, 5'd0);
                put_char(SEP_CHAR);
            end
            if (first_err == ST_OK && int'(n_chars) + CHK_CHARS + 1 > ADDR_MAX_LEN)
                first_err = ST_TOO_LONG;
            st = first_err;
            for (i = 0; i < CHK_CHARS; i++) chk = poly_step(chk, 5'd0);
            chk[0] = ~chk[0];
            for (i = 0; i < CHK_CHARS; i++)
                put_char(CHARSET[chk[5*(CHK_CHARS-1-i) +: 5]]);
            word_buf[n_buf-1].fin = 1'b1;
            word_buf[n_buf-1].st  = st;
            clear_state();
        end

        for (i = 0; i < n_buf; i++) exp_chars.push_back(word_buf[i]);
    endtask

    // compare one output word with the oldest expected character
    task automatic check_char();
        addr_char_t want;
        if (exp_chars.size() == 0) begin
            $display("%0t: unexpected word: expected none, actual char %h final %b status %0d",
                     $time, m_out_char, m_final_res, m_status);
            err_count++;
        end else begin
            want = exp_chars.pop_front();
            if (m_out_char !== want.ch) begin
                $display("%0t: out_char mismatch: expected %h actual %h",
                         $time, want.ch, m_out_char);
                err_count++;
            end
            if (m_final_res !== want.fin) begin
                $display("%0t: final_res mismatch: expected %b actual %b",
                         $time, want.fin, m_final_res);
                err_count++;
            end
            if (m_status !== want.st) begin
                $display("%0t: status mismatch: expected %0d actual %0d",
                         $time, want.st, m_status);
                err_count++;
            end
        end
    endtask

    // sample both channels at the clock edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_state();
            exp_chars.delete();
            pending <= 0;
        end else begin
            if (m_valid && m_ready) check_char();
            if (s_valid && s_ready) predict_chars(s_cmd, s_value, s_last);
            pending <= exp_chars.size();
        end
    end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the checksummed address encoder with a directed set of addresses
// (field extremes, every fault kind but too long, empty prefix, empty data
// part) followed by random addresses, mostly well formed, some with one broken
// word and some pure noise. The sender idles in random bursts, the receiver
// stalls on its own pattern; addr_char_checker does the checking.
// ----------------------------------------------------------------------------
module tb_top;
    import cae_pkg::*;

    localparam logic CMD_PREFIX = 1'b0;
    localparam logic CMD_SYMBOL = 1'b1;

    localparam int STIM_WORDS     = 290;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;

    // receiver stall modes
    localparam int RX_FREE  = 0;
    localparam int RX_LIGHT = 1;
    localparam int RX_HEAVY = 2;
    localparam int RX_BEAT  = 3;

    logic       aclk    = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic       s_cmd   = CMD_PREFIX;
    logic [7:0] s_value = 8'h0;
    logic       s_last  = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_char;
    logic       m_final_res;
    logic [2:0] m_status;

    int err_count;
    int pending;
    int quiet_cycles = 0;
    int words_sent   = 0;
    int burst_left   = 0;
    bit tx_gaps      = 1'b1;
    int rx_mode      = RX_FREE;
    int rx_left      = 0;

    checksummed_address_encoder dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_value     (s_value),
        .s_last      (s_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_char  (m_out_char),
        .m_final_res (m_final_res),
        .m_status    (m_status)
    );

    addr_char_checker chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_value     (s_value),
        .s_last      (s_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_char  (m_out_char),
        .m_final_res (m_final_res),
        .m_status    (m_status),
        .err_count   (err_count),
        .pending     (pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // receiver: stall mode is picked anew whenever rx_left runs out
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(RX_FREE, RX_BEAT);
            rx_left <= $urandom_range(20, 80);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_FREE:  m_ready <= 1'b1;
            RX_LIGHT: m_ready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY: m_ready <= ($urandom_range(0, 9) < 3);
            default:  m_ready <= rx_left[2];
        endcase
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // present one word and hold it until taken
    task automatic send_word(input logic cmd, input logic [7:0] val, input logic last);
        bit taken;
        int gap;
        if (tx_gaps && burst_left == 0) begin
            gap = $urandom_range(1, 6);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = $urandom_range(1, 16);
        end
        s_valid <= 1'b1;
        s_cmd   <= cmd;
        s_value <= val;
        s_last  <= last;
        do begin
            @(negedge aclk);
            taken = s_ready;
            @(posedge aclk);
        end while (!taken);
        words_sent++;
        if (burst_left > 0) burst_left--;
    endtask

    // stop sending until every expected character has come out
    task automatic hold_until_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        @(posedge aclk);
    endtask

    // one random address: clean, with one broken word, or pure noise
    task automatic send_random_addr();
        int         len;
        int         plen;
        int         kind;
        int         bad_pos;
        int         sel;
        int         i;
        logic       cmd;
        logic [7:0] v;
        sel = $urandom_range(0, 19);
        if (sel < 14)      len = $urandom_range(1, 12);
        else if (sel < 18) len = $urandom_range(13, 40);
        else               len = $urandom_range(78, 88);
        if ($urandom_range(0, 9) == 0) plen = len;
        else                           plen = $urandom_range(0, len - 1);
        kind    = $urandom_range(0, 9);
        bad_pos = (kind == 2 || kind == 3) ? $urandom_range(0, len - 1) : -1;
        tx_gaps = ($urandom_range(0, 3) != 0);
        for (i = 0; i < len; i++) begin
            if (kind < 2) begin
                cmd = 1'($urandom_range(0, 1));
                v   = 8'($urandom_range(0, 255));
            end else if (i < plen) begin
                // printable, never upper case
                cmd = CMD_PREFIX;
                v   = 8'($urandom_range(33, 100));
                if (v >= UPPER_MIN) v = v + 8'd26;
            end else begin
                cmd = CMD_SYMBOL;
                v   = 8'($urandom_range(0, 31));
            end
            if (i == bad_pos) begin
                cmd = 1'($urandom_range(0, 1));
                v   = 8'($urandom_range(0, 255));
            end
            send_word(cmd, v, i == len - 1);
        end
    endtask

    initial begin : stimulus
        int  base;
        bit  paused;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // extremes of the printable range, symbols 0 and 31
        send_word(CMD_PREFIX, 8'd33, 1'b0);
        send_word(CMD_PREFIX, 8'd126, 1'b0);
        send_word(CMD_SYMBOL, 8'd0, 1'b0);
        send_word(CMD_SYMBOL, 8'd31, 1'b1);
        // no data part, then no prefix
        send_word(CMD_PREFIX, "q", 1'b1);
        send_word(CMD_SYMBOL, 8'd7, 1'b1);
        // bytes outside the printable range
        send_word(CMD_PREFIX, 8'd0, 1'b0);
        send_word(CMD_PREFIX, 8'd32, 1'b0);
        send_word(CMD_PREFIX, 8'd127, 1'b0);
        send_word(CMD_PREFIX, 8'd255, 1'b0);
        send_word(CMD_SYMBOL, 8'd1, 1'b1);
        // neighbors of the upper case range, then upper case
        send_word(CMD_PREFIX, "@", 1'b0);
        send_word(CMD_PREFIX, "[", 1'b0);
        send_word(CMD_PREFIX, "A", 1'b0);
        send_word(CMD_PREFIX, "Z", 1'b0);
        send_word(CMD_SYMBOL, 8'd2, 1'b1);
        // symbols out of range
        send_word(CMD_SYMBOL, 8'd32, 1'b0);
        send_word(CMD_SYMBOL, 8'd255, 1'b1);
        // prefix after data, ending on a prefix byte
        send_word(CMD_PREFIX, "x", 1'b0);
        send_word(CMD_SYMBOL, 8'd3, 1'b0);
        send_word(CMD_PREFIX, "y", 1'b1);
        // order fault first, so the later upper case one is not kept
        send_word(CMD_SYMBOL, 8'd4, 1'b0);
        send_word(CMD_PREFIX, "Z", 1'b1);

        // random addresses, with one full drain halfway
        base   = words_sent;
        paused = 1'b0;
        while (words_sent - base < STIM_WORDS) begin
            send_random_addr();
            if (!paused && words_sent - base >= STIM_WORDS / 2) begin
                hold_until_drained();
                paused = 1'b1;
            end
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[files.f]
sv/cae_pkg.sv
sv/cae_emitter.sv
sv/checksummed_address_encoder.sv
verif/addr_char_checker.sv
verif/tb_top.sv
